[design/assert_macros.svh]
// Assertion helpers for the wheel speed block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/dtm_pkg.sv]
package dtm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ZW               = 28;   // angle accumulator, 2^-24 rad
    localparam int CW               = 34;   // cordic x/y datapath width
    localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
    localparam logic [15:0] PI_Q13  = 16'd25736;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    // register indexes
    localparam logic [1:0] REG_HARD = 2'd0;
    localparam logic [1:0] REG_SOFT = 2'd1;
    localparam logic [1:0] REG_NONE = 2'd2;
    localparam logic [1:0] REG_MAXS = 2'd3;

    // turn modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SOFT = 2'd1;
    localparam logic [1:0] MODE_HARD = 2'd2;

    localparam logic [14:0] HARD_RST = 15'd12868;
    localparam logic [14:0] SOFT_RST = 15'd10008;
    localparam logic [14:0] NONE_RST = 15'd1430;
    localparam logic [14:0] MAXS_RST = 15'd2560;

    // arctan(2^-i) in 2^-24 rad
    function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
        logic [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = 28'd13176795;
                5'd1:  r = 28'd7778716;
                5'd2:  r = 28'd4110060;
                5'd3:  r = 28'd2086331;
                5'd4:  r = 28'd1047214;
                5'd5:  r = 28'd524117;
                5'd6:  r = 28'd262123;
                5'd7:  r = 28'd131069;
                default:
                begin
                    if (i < 5'd24)
                        r = ZW'(28'd65536 >> (i - 5'd8));
                    else
                        r = '0;
                end
            endcase
            return r;
        end
    endfunction

endpackage

[design/dtm_cordic.sv]
// Iterative CORDIC vectoring: one rotation step per cycle, x and y shifted by
// the step index, angle accumulated from the arctan table.
module dtm_cordic #(
    parameter int CORDIC_STEPS = dtm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [15:0]                hx,
    input  logic signed [15:0]                hy,
    output logic                              done,
    output logic signed [dtm_pkg::CW-1:0]     x_out,
    output logic signed [dtm_pkg::ZW-1:0]     z_out
);

    localparam int NSTEP = (CORDIC_STEPS < dtm_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : dtm_pkg::ATAN_ENTRIES;

    logic signed [dtm_pkg::CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [dtm_pkg::ZW-1:0] z_reg, z_next;
    logic [4:0] i_reg, i_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic signed [dtm_pkg::CW-1:0] xs, ys, x0, y0;
    logic signed [dtm_pkg::ZW-1:0] z0;

    // pre-rotation into the right half plane, scaled by 2^16
    always_comb
    begin
        x0 = dtm_pkg::CW'(hx) <<< 16;
        y0 = dtm_pkg::CW'(hy) <<< 16;
        z0 = '0;
        if (hx < 0)
        begin
            z0 = (hy >= 0) ? dtm_pkg::PI_Q24 : -dtm_pkg::PI_Q24;
            x0 = -x0;
            y0 = -y0;
        end
    end

    // one micro-rotation per cycle (arithmetic shift is floor)
    always_comb
    begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next = x0;
            y_next = y0;
            z_next = z0;
            i_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + dtm_pkg::atan_lut(i_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - dtm_pkg::atan_lut(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(NSTEP - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

[design/differential_turn_mode_wheel_speeds_top.sv]
// Differential-drive wheel speeds from a heading vector. One word in gives
// one word out. From the accepting edge to the result word an item passes
// through one-step-per-cycle CORDIC vectoring, a bit-serial length
// multiply, a restoring divide for the soft turn term, and the steps of
// hand-off, rounding, dividend load and output. The next input word is taken
// once the sequencer is idle, even while the previous result waits in the
// output register; a stalled result holds the next item at its output step.
// Config writes must happen idle.
`include "assert_macros.svh"

module differential_turn_mode_wheel_speeds_top #(
    parameter int CORDIC_STEPS = dtm_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // heading_x[15:0], heading_y[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // left_speed[16:0], right_speed[33:17],
                                    // turn_mode[35:34], zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CORD = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_MODE = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [14:0] hard_reg, soft_reg, none_reg, maxs_reg;
    logic [1:0]  mode_reg, mode_next;
    logic        cord_start;
    logic        cord_done;
    logic signed [dtm_pkg::CW-1:0] cx;
    logic signed [dtm_pkg::ZW-1:0] cz;
    logic        zero_reg;
    logic signed [16:0] ang_reg, ang_next;
    logic [49:0] prod_reg, prod_next;    // length product accumulator
    logic [33:0] mcand_reg, mcand_next;
    logic [15:0] mplier_reg, mplier_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [16:0] len_reg, len_next;
    logic [31:0] quo_reg, quo_next;      // dividend shifts into quotient
    logic [15:0] rem_reg, rem_next;
    logic [16:0] rtrial;
    logic        mout_vld_reg, mout_vld_next;
    logic [39:0] mout_reg, mout_next;
    logic [15:0] a_abs;
    logic [15:0] base;
    logic signed [dtm_pkg::ZW:0] zr;
    logic signed [17:0] s1, s2, lft, rgt;
    logic [16:0] delta;
    logic [1:0]  m1, m2, m3;

    dtm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .hx    (s_tdata[15:0]),
        .hy    (s_tdata[31:16]),
        .done  (cord_done),
        .x_out (cx),
        .z_out (cz)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_reg <= dtm_pkg::HARD_RST;
            soft_reg <= dtm_pkg::SOFT_RST;
            none_reg <= dtm_pkg::NONE_RST;
            maxs_reg <= dtm_pkg::MAXS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtm_pkg::REG_HARD: hard_reg <= cfg_data;
                dtm_pkg::REG_SOFT: soft_reg <= cfg_data;
                dtm_pkg::REG_NONE: none_reg <= cfg_data;
                dtm_pkg::REG_MAXS: maxs_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cord_start = (state_reg == ST_IDLE) && s_tvalid && s_tready;
    assign a_abs = ang_reg[16] ? 16'(-ang_reg) : ang_reg[15:0];
    assign base  = (len_reg < 17'(maxs_reg)) ? len_reg[15:0] : 16'(maxs_reg);
    assign rtrial = {rem_reg, quo_reg[31]} - {2'b0, hard_reg};

    // angle rounding and clamp
    always_comb
    begin
        zr = ((dtm_pkg::ZW+1)'(cz) + (dtm_pkg::ZW+1)'(1024)) >>> 11;
        if (zr > $signed((dtm_pkg::ZW+1)'(dtm_pkg::PI_Q13)))
            ang_next = 17'(dtm_pkg::PI_Q13);
        else if (zr < -$signed((dtm_pkg::ZW+1)'(dtm_pkg::PI_Q13)))
            ang_next = -17'(dtm_pkg::PI_Q13);
        else
            ang_next = 17'(zr);
    end

    // mode update cascade
    always_comb
    begin
        m1 = mode_reg;
        if (m1 == dtm_pkg::MODE_HARD && a_abs <= 16'(soft_reg))
            m1 = dtm_pkg::MODE_SOFT;
        m2 = m1;
        if (m2 == dtm_pkg::MODE_SOFT)
        begin
            if (a_abs > 16'(hard_reg))
                m2 = dtm_pkg::MODE_HARD;
            else if (a_abs <= 16'(none_reg))
                m2 = dtm_pkg::MODE_NONE;
        end
        m3 = m2;
        if (m3 == dtm_pkg::MODE_NONE)
        begin
            if (a_abs > 16'(hard_reg))
                m3 = dtm_pkg::MODE_HARD;
            else if (a_abs > 16'(none_reg))
                m3 = dtm_pkg::MODE_SOFT;
        end
    end

    // wheel assembly
    always_comb
    begin
        delta = (hard_reg == '0) ? '0 : quo_reg[16:0];
        if (delta > 17'(base))
            delta = 17'(base);
        if (mode_reg == dtm_pkg::MODE_HARD)
        begin
            s1 = -18'(maxs_reg);
            s2 = 18'(maxs_reg);
        end
        else if (mode_reg == dtm_pkg::MODE_SOFT)
        begin
            s1 = 18'(base) - 18'(delta);
            s2 = 18'(base) + 18'(delta);
        end
        else
        begin
            s1 = 18'(base);
            s2 = 18'(base);
        end
        if (ang_reg > 0)
        begin
            lft = s1;
            rgt = s2;
        end
        else
        begin
            lft = s2;
            rgt = s1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        prod_next    = prod_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        mout_vld_next = mout_vld_reg && !m_tready;
        mout_next    = mout_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cord_start)
                    state_next = ST_CORD;
            end
            ST_CORD:
            begin
                if (cord_done)
                begin
                    mcand_next  = cx[dtm_pkg::CW-1] ? '0 : cx[33:0];
                    mplier_next = dtm_pkg::INV_GAIN_Q16;
                    prod_next   = '0;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add, one multiplier bit per cycle
                if (mplier_reg[0])
                    prod_next = prod_reg + (50'(mcand_reg) << cnt_reg[3:0]);
                mplier_next = mplier_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                    state_next = ST_MODE;
            end
            ST_MODE:
            begin
                len_next = 17'((prod_next + 50'h80000000) >> 32);
                if (zero_reg)
                    len_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // count 16 marks the dividend load, steps run at counts 32 to 63
                if (cnt_reg == 6'd16)
                begin
                    mode_next = m3;
                    quo_next = base * a_abs;
                    rem_next = '0;
                    cnt_next = 6'd32;
                end
                else
                begin
                    if (!rtrial[16])
                    begin
                        rem_next = rtrial[15:0];
                        quo_next = {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[14:0], quo_reg[31]};
                        quo_next = {quo_reg[30:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!mout_vld_reg || m_tready)
                begin
                    mout_vld_next = 1'b1;
                    mout_next = {4'b0, mode_reg, rgt[16:0], lft[16:0]};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= dtm_pkg::MODE_NONE;
            mout_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            mout_vld_reg <= mout_vld_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cord_start)
            zero_reg <= (s_tdata == '0);
        if (cord_done)
            ang_reg <= zero_reg ? '0 : ang_next;
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        len_reg    <= len_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        mout_reg   <= mout_next;
    end

    assign m_tvalid = mout_vld_reg;
    assign m_tdata  = mout_reg;

    `ASSERT_ALWAYS(a_mode_legal, mode_reg != 2'd3, "turn mode out of range")
    `ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg == ST_CORD,
        "accepted word did not start cordic")
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result word changed while stalled")

endmodule
